@@ src/oit_pkg.sv @@
// Shared types and constants of the indentation tokenizer.
`default_nettype none

package oit_pkg;

    localparam int LINE_W   = 20;
    localparam int TAB_STOP = 4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_HASH  = 8'h23;

    typedef enum logic [2:0] {
        KIND_INDENT   = 3'd0,
        KIND_DEDENT   = 3'd1,
        KIND_NEWLINE  = 3'd2,
        KIND_EOF      = 3'd3,
        KIND_DEEP     = 3'd4,
        KIND_MISMATCH = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        SCAN_START,
        SCAN_BODY,
        SCAN_COMMENT
    } t_scan;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_POP_STEP,
        ST_BURST
    } t_state;

    typedef struct packed {
        logic accept;
        logic pop_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
        logic eot;
        logic pop_start;
        logic pop_again;
        logic burst_last;
    } t_status;

endpackage

`default_nettype wire

@@ src/oit_if.sv @@
// Valid/ready channels for text bytes in and tokens out.
`default_nettype none

interface oit_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       in_literal;
    logic       end_of_text;

    modport source(output valid, output text_byte, output in_literal, output end_of_text,
                   input ready);
    modport sink(input valid, input text_byte, input in_literal, input end_of_text,
                 output ready);
endinterface

interface oit_token_if import oit_pkg::*; ;
    logic              valid;
    logic              ready;
    t_kind             token_kind;
    logic [LINE_W-1:0] line_number;
    logic              last_of_run;

    modport source(output valid, output token_kind, output line_number, output last_of_run,
                   input ready);
    modport sink(input valid, input token_kind, input line_number, input last_of_run,
                 output ready);
endinterface

`default_nettype wire

@@ src/oit_datapath.sv @@
// Scan state, indent level stack, pop and burst counters, token output register.
`default_nettype none

module oit_datapath import oit_pkg::*; #(
    parameter int NEST_DEPTH = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [7:0]        i_text_byte,
    input  wire logic              i_in_literal,
    input  wire logic              i_end_of_text,
    input  wire logic              i_out_ready,
    output t_status                o_status,
    output logic                   o_out_valid,
    output t_kind                  o_token_kind,
    output logic [LINE_W-1:0]      o_line_number,
    output logic                   o_last_of_run
);

    localparam int TW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    t_scan                 r_scan, n_scan;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [LINE_W-1:0]     r_line, n_line;
    logic [TW-1:0]         r_top, n_top;
    logic [COUNT_BITS-1:0] r_top_val, n_top_val;
    logic                  r_out_valid, n_out_valid;

    logic [TW-1:0]         r_pops, n_pops;
    logic                  r_mis, n_mis;
    logic                  r_eof, n_eof;
    logic [LINE_W-1:0]     r_tok_line, n_tok_line;
    t_kind                 r_kind, n_kind;
    logic [LINE_W-1:0]     r_oline, n_oline;
    logic                  r_last, n_last;

    logic [COUNT_BITS-1:0] r_mem [NEST_DEPTH];
    logic [COUNT_BITS-1:0] r_rd;
    logic                  mem_we;
    logic [TW-1:0]         mem_wa;
    logic [TW-1:0]         rd_addr;

    logic                  is_space, is_tab, is_nl, is_hash, byte_nl;
    logic                  content, body_nl, cnt_gt, cnt_lt, full;
    logic [LINE_W-1:0]     line_inc;
    logic [COUNT_BITS-1:0] count_inc, count_tab;
    logic [COUNT_BITS:0]   tab_sum;
    logic [COUNT_BITS-1:0] below;
    t_kind                 emit_kind;
    logic                  emit_last;

    // byte classes; a literal byte is never a blank, newline or comment mark (byte_nl still sees a literal newline)
    assign byte_nl  = (i_text_byte == CHAR_NL);
    assign is_space = !i_in_literal && (i_text_byte == CHAR_SPACE);
    assign is_tab   = !i_in_literal && (i_text_byte == CHAR_TAB);
    assign is_nl    = !i_in_literal && byte_nl;
    assign is_hash  = !i_in_literal && (i_text_byte == CHAR_HASH);

    assign content = (r_scan == SCAN_START) && !(is_space || is_tab || is_nl || is_hash);
    assign body_nl = (r_scan != SCAN_START) && (r_scan != SCAN_COMMENT) && is_nl;
    assign cnt_gt  = r_count > r_top_val;
    assign cnt_lt  = r_count < r_top_val;
    assign full    = (r_top == TW'(NEST_DEPTH - 1));

    assign line_inc  = (r_line == {LINE_W{1'b1}}) ? r_line : r_line + 1'b1;
    assign count_inc = (r_count == {COUNT_BITS{1'b1}}) ? r_count : r_count + 1'b1;
    assign tab_sum   = {1'b0, r_count & ~COUNT_BITS'(TAB_STOP - 1)}
                     + (COUNT_BITS + 1)'(TAB_STOP);
    assign count_tab = tab_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : tab_sum[COUNT_BITS-1:0];

    // entry zero is always level 0 and lives in no memory word
    assign rd_addr = r_top - 1'b1;
    assign below   = (r_top == TW'(1)) ? '0 : r_rd;

    always_comb begin
        emit_kind = KIND_EOF;
        emit_last = 1'b1;
        if (r_mis) begin
            emit_kind = KIND_MISMATCH;
            emit_last = (r_pops == '0) && !r_eof;
        end else if (r_pops != '0) begin
            emit_kind = KIND_DEDENT;
            emit_last = (r_pops == TW'(1)) && !r_eof;
        end
    end

    assign o_status.out_busy   = r_out_valid;
    assign o_status.eot        = i_end_of_text;
    assign o_status.pop_start  = !i_end_of_text && content && cnt_lt;
    assign o_status.pop_again  = r_count < below;
    assign o_status.burst_last = emit_last;

    always_comb begin
        n_scan      = r_scan;
        n_count     = r_count;
        n_line      = r_line;
        n_top       = r_top;
        n_top_val   = r_top_val;
        n_pops      = r_pops;
        n_mis       = r_mis;
        n_eof       = r_eof;
        n_tok_line  = r_tok_line;
        n_kind      = r_kind;
        n_oline     = r_oline;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_wa      = r_top + 1'b1;

        if (i_cmd.accept) begin
            if (i_end_of_text) begin
                // close every open level, then end of text
                n_pops     = r_top;
                n_mis      = 1'b0;
                n_eof      = 1'b1;
                n_tok_line = r_line;
                n_top      = '0;
                n_top_val  = '0;
                n_scan     = SCAN_START;
                n_count    = '0;
            end else begin
                case (r_scan)
                    SCAN_START: begin
                        if (is_space) begin
                            n_count = count_inc;
                        end else if (is_tab) begin
                            n_count = count_tab;
                        end else if (is_nl) begin
                            n_line  = line_inc;
                            n_count = '0;
                        end else if (is_hash) begin
                            n_scan = SCAN_COMMENT;
                        end else begin
                            n_scan     = SCAN_BODY;
                            n_tok_line = r_line;
                            if (byte_nl) begin
                                n_line = line_inc;
                            end
                            if (cnt_gt) begin
                                n_out_valid = 1'b1;
                                n_oline     = r_line;
                                n_last      = 1'b1;
                                if (full) begin
                                    n_kind = KIND_DEEP;
                                end else begin
                                    n_kind    = KIND_INDENT;
                                    mem_we    = 1'b1;
                                    n_top     = r_top + 1'b1;
                                    n_top_val = r_count;
                                end
                            end else if (cnt_lt) begin
                                n_pops = '0;
                                n_mis  = 1'b0;
                                n_eof  = 1'b0;
                            end
                        end
                    end
                    SCAN_COMMENT: begin
                        if (byte_nl) begin
                            n_line  = line_inc;
                            n_count = '0;
                            n_scan  = SCAN_START;
                        end
                    end
                    default: begin
                        if (byte_nl) begin
                            n_line = line_inc;
                        end
                        if (body_nl) begin
                            n_out_valid = 1'b1;
                            n_kind      = KIND_NEWLINE;
                            n_oline     = line_inc;
                            n_last      = 1'b1;
                            n_scan      = SCAN_START;
                            n_count     = '0;
                        end
                    end
                endcase
            end
        end

        if (i_cmd.pop_step) begin
            n_top     = r_top - 1'b1;
            n_top_val = below;
            n_pops    = r_pops + 1'b1;
            n_mis     = (r_count != below);
        end

        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_kind      = emit_kind;
            n_oline     = r_tok_line;
            n_last      = emit_last;
            if (r_mis) begin
                n_mis = 1'b0;
            end else if (r_pops != '0) begin
                n_pops = r_pops - 1'b1;
            end else begin
                n_eof = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan      <= SCAN_START;
            r_count     <= '0;
            r_line      <= LINE_W'(1);
            r_top       <= '0;
            r_top_val   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_scan      <= n_scan;
            r_count     <= n_count;
            r_line      <= n_line;
            r_top       <= n_top;
            r_top_val   <= n_top_val;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pops     <= n_pops;
        r_mis      <= n_mis;
        r_eof      <= n_eof;
        r_tok_line <= n_tok_line;
        r_kind     <= n_kind;
        r_oline    <= n_oline;
        r_last     <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= r_count;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign o_out_valid   = r_out_valid;
    assign o_token_kind  = r_kind;
    assign o_line_number = r_oline;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

@@ src/oit_ctrl.sv @@
// Sequencer: byte intake, stack pop loop and token burst.
`default_nettype none

module oit_ctrl import oit_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;
    logic   out_free;
    logic   accept;

    // the output register can take a token this cycle
    assign out_free = !i_status.out_busy || i_out_ready;
    assign accept   = i_in_valid && (r_state == ST_IDLE) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_status.eot) begin
                    n_state = ST_BURST;
                end else if (accept && i_status.pop_start) begin
                    n_state = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT: begin
                n_state = ST_POP_STEP;
            end
            ST_POP_STEP: begin
                n_state = i_status.pop_again ? ST_POP_WAIT : ST_BURST;
            end
            ST_BURST: begin
                if (out_free && i_status.burst_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE) && out_free;
        o_cmd.accept   = accept;
        o_cmd.pop_step = (r_state == ST_POP_STEP);
        o_cmd.emit     = (r_state == ST_BURST) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ src/offside_indent_tokenizer_top.sv @@
// Top level of the indentation tokenizer: sequencer plus datapath.
//
//  channel   dir  payload                                   moves
//  i_text    in   text_byte, in_literal, end_of_text        one source byte or end mark
//  o_token   out  token_kind, line_number, last_of_run      one token
//
// A byte that makes no token or a single token (INDENT, NEWLINE, too deep) is taken in
// IDLE, so plain text streams at one byte a cycle while the receiver keeps up. A dedent
// popping k levels runs POP_WAIT (stack read) and POP_STEP per pop, then sends a mismatch
// if any and k DEDENTs. End of text with d open levels sends d DEDENTs, then EOF.
// Reset is synchronous; the stack memory is not cleared, entry zero is implied.
// The token register lets the next byte enter in the cycle the pending token leaves.
`default_nettype none

module offside_indent_tokenizer_top import oit_pkg::*; #(
    parameter int NEST_DEPTH = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    oit_text_if.sink     i_text,
    oit_token_if.source  o_token
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // sequencing: when to take a byte, step the pop loop, or advance the burst
    oit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_text.valid),
        .i_out_ready (o_token.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_cmd       (cmd)
    );

    // scan state, level stack and the token register
    oit_datapath #(
        .NEST_DEPTH (NEST_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_text_byte   (i_text.text_byte),
        .i_in_literal  (i_text.in_literal),
        .i_end_of_text (i_text.end_of_text),
        .i_out_ready   (o_token.ready),
        .o_status      (status),
        .o_out_valid   (o_token.valid),
        .o_token_kind  (o_token.token_kind),
        .o_line_number (o_token.line_number),
        .o_last_of_run (o_token.last_of_run)
    );

    assign i_text.ready = in_ready;

endmodule

`default_nettype wire

@@ bench/offside_indent_tokenizer_top_tb.sv @@
// Self-checking bench for the indentation tokenizer: directed table, then random source text.
`timescale 1ns / 1ps

module offside_indent_tokenizer_top_tb;
    import oit_pkg::*;

    localparam int NEST_DEPTH   = 32;
    localparam int COUNT_BITS   = 16;
    // Several times the slowest legal run: ~350 requests, each up to NEST_DEPTH tokens
    // behind a receiver that stalls half the time, plus the stack pops.
    localparam int CYCLE_LIMIT  = 400000;
    // A dedent that unwinds the full stack pops NEST_DEPTH-1 levels before its tokens leave.
    localparam int SETTLE_CYCLES = 4 * NEST_DEPTH + 40;
    localparam int PHASE_ITEMS  = 30;
    localparam int DIRECTED_ROWS = 25;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [LINE_W-1:0]     LINE_MAX  = '1;
    localparam logic [7:0]            CHAR_CR   = 8'h0D;
    localparam logic [7:0]            CHAR_X    = 8'h78;

    typedef struct packed {
        t_kind             kind;
        logic [LINE_W-1:0] line;
        logic              last;
    } t_token;

    // One directed request. With pinned set, the row carries its single token by hand.
    typedef struct packed {
        logic [7:0]        text_byte;
        logic              lit;
        logic              eot;
        logic              pinned;
        t_kind             kind;
        logic [LINE_W-1:0] line;
    } t_text_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    oit_text_if  text_ch ();
    oit_token_if token_ch ();

    offside_indent_tokenizer_top #(
        .NEST_DEPTH(NEST_DEPTH),
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_text (text_ch),
        .o_token(token_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the tokenizer state, advanced on every accepted request.
    t_scan                 line_scan;
    logic [COUNT_BITS-1:0] blanks;
    logic [COUNT_BITS-1:0] open_levels [NEST_DEPTH];
    int                    open_depth;
    logic [LINE_W-1:0]     cur_line;

    t_token fresh_tokens [$];   // tokens made by the latest request
    t_token tokens_due   [$];   // tokens still owed by the block

    int gap_pct;
    int stall_pct;
    int phase_items;
    int failures;
    int cycle_count;

    // Walk from a fresh reset through every token kind but too deep (left to the
    // deep-nesting pass): blank and comment lines, literal bytes at line start, a
    // literal newline ending a comment, carriage return as content, a mismatched
    // dedent, and the byte extremes.
    t_text_row dir_rows [DIRECTED_ROWS] = '{
        '{8'hFF,      1'b0, 1'b1, 1'b1, KIND_EOF,     20'd1},
        '{CHAR_NL,    1'b0, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_SPACE, 1'b0, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_TAB,   1'b0, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_HASH,  1'b0, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_X,     1'b1, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_NL,    1'b1, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{8'h00,      1'b0, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_NL,    1'b1, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_NL,    1'b0, 1'b0, 1'b1, KIND_NEWLINE, 20'd5},
        '{CHAR_TAB,   1'b0, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_CR,    1'b0, 1'b0, 1'b1, KIND_INDENT,  20'd5},
        '{CHAR_NL,    1'b0, 1'b0, 1'b1, KIND_NEWLINE, 20'd6},
        '{CHAR_SPACE, 1'b0, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_SPACE, 1'b0, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_X,     1'b0, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_NL,    1'b0, 1'b0, 1'b1, KIND_NEWLINE, 20'd7},
        '{CHAR_SPACE, 1'b1, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_NL,    1'b0, 1'b0, 1'b1, KIND_NEWLINE, 20'd8},
        '{CHAR_TAB,   1'b0, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_HASH,  1'b1, 1'b0, 1'b1, KIND_INDENT,  20'd8},
        '{CHAR_NL,    1'b1, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{CHAR_NL,    1'b0, 1'b0, 1'b1, KIND_NEWLINE, 20'd10},
        '{CHAR_NL,    1'b1, 1'b0, 1'b0, KIND_INDENT,  20'd0},
        '{8'h00,      1'b0, 1'b1, 1'b1, KIND_EOF,     20'd11}
    };

    function automatic void clear_tracker();
        line_scan  = SCAN_START;
        blanks     = '0;
        open_depth = 0;
        cur_line   = 20'd1;
        foreach (open_levels[i]) open_levels[i] = '0;
    endfunction

    function automatic void book_token(input t_kind kind);
        t_token tok;
        tok.kind = kind;
        tok.line = cur_line;
        tok.last = 1'b0;
        fresh_tokens.push_back(tok);
    endfunction

    function automatic void bump_line();
        if (cur_line != LINE_MAX) cur_line = cur_line + 1'b1;
    endfunction

    // First content byte of a line: open a level, close some, flag an error, or change nothing.
    function automatic void settle_indent();
        int pops;
        pops = 0;
        if (blanks > open_levels[open_depth]) begin
            if (open_depth + 1 >= NEST_DEPTH) begin
                book_token(KIND_DEEP);
            end else begin
                open_depth++;
                open_levels[open_depth] = blanks;
                book_token(KIND_INDENT);
            end
        end else if (blanks < open_levels[open_depth]) begin
            while (open_depth > 0 && blanks < open_levels[open_depth]) begin
                open_depth--;
                pops++;
            end
            if (blanks != open_levels[open_depth]) book_token(KIND_MISMATCH);
            repeat (pops) book_token(KIND_DEDENT);
        end
    endfunction

    // Advance the shadow state by one request and leave its tokens in fresh_tokens.
    function automatic void track_indent(input logic [7:0] b, input logic lit,
                                         input logic eot);
        logic [COUNT_BITS+2:0] tab_stop;
        fresh_tokens.delete();
        if (eot) begin
            while (open_depth > 0) begin
                open_depth--;
                book_token(KIND_DEDENT);
            end
            book_token(KIND_EOF);
            line_scan = SCAN_START;
            blanks    = '0;
        end else if (line_scan == SCAN_START) begin
            if (!lit && b == CHAR_SPACE) begin
                if (blanks != COUNT_MAX) blanks = blanks + 1'b1;
            end else if (!lit && b == CHAR_TAB) begin
                tab_stop = (COUNT_BITS + 3)'(blanks + TAB_STOP - (blanks % TAB_STOP));
                blanks   = (tab_stop > COUNT_MAX) ? COUNT_MAX : tab_stop[COUNT_BITS-1:0];
            end else if (!lit && b == CHAR_NL) begin
                bump_line();
                blanks = '0;
            end else if (!lit && b == CHAR_HASH) begin
                line_scan = SCAN_COMMENT;
            end else begin
                settle_indent();
                line_scan = SCAN_BODY;
                if (b == CHAR_NL) bump_line();
            end
        end else if (line_scan == SCAN_COMMENT) begin
            // The literal flag means nothing inside a comment-only line.
            if (b == CHAR_NL) begin
                bump_line();
                blanks    = '0;
                line_scan = SCAN_START;
            end
        end else if (b == CHAR_NL) begin
            bump_line();
            if (!lit) begin
                book_token(KIND_NEWLINE);
                line_scan = SCAN_START;
                blanks    = '0;
            end
        end
        if (fresh_tokens.size() > 0) fresh_tokens[fresh_tokens.size() - 1].last = 1'b1;
    endfunction

    // Offer one request, hold it until taken, then book the tokens it owes.
    task automatic send_byte(input logic [7:0] b, input logic lit, input logic eot,
                             input logic pinned, input t_kind kind,
                             input logic [LINE_W-1:0] line);
        t_token tok;
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            text_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.in_literal  <= lit;
        text_ch.end_of_text <= eot;
        do @(posedge i_clk); while (text_ch.ready !== 1'b1);
        track_indent(b, lit, eot);
        if (pinned) begin
            tok.kind = kind;
            tok.line = line;
            tok.last = 1'b1;
            tokens_due.push_back(tok);
        end else begin
            foreach (fresh_tokens[i]) tokens_due.push_back(fresh_tokens[i]);
        end
        phase_items++;
    endtask

    task automatic send_text(input logic [7:0] b, input logic lit);
        send_byte(b, lit, 1'b0, 1'b0, KIND_INDENT, '0);
    endtask

    task automatic send_blanks(input int target, input logic tabs_first);
        int col;
        int step;
        col = 0;
        while (col < target) begin
            step = TAB_STOP - (col % TAB_STOP);
            if (step <= target - col && (tabs_first || $urandom_range(1) == 1)) begin
                send_text(CHAR_TAB, 1'b0);
                col += step;
            end else begin
                send_text(CHAR_SPACE, 1'b0);
                col++;
            end
        end
    endtask

    // Indented line of content closed by a plain newline; literal bytes sprinkled in.
    task automatic send_code_line(input int target, input int max_extra,
                                  input logic tabs_first);
        logic [7:0] b;
        logic       lit;
        send_blanks(target, tabs_first);
        b   = 8'($urandom_range(255));
        lit = ($urandom_range(7) == 0);
        if (!lit && (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_NL || b == CHAR_HASH))
            b = CHAR_X;
        send_text(b, lit);
        repeat ($urandom_range(max_extra)) begin
            lit = ($urandom_range(3) == 0);
            b   = ($urandom_range(9) == 0) ? CHAR_NL : 8'($urandom_range(255));
            if (!lit && b == CHAR_NL) b = CHAR_X;
            send_text(b, lit);
        end
        send_text(CHAR_NL, 1'b0);
    endtask

    // Mostly well-formed: stay, open one level, return to an open level; sometimes miss.
    function automatic int pick_indent();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35) return int'(open_levels[open_depth]);
        if (roll < 60) return int'(open_levels[open_depth]) + $urandom_range(1, 6);
        if (roll < 85) return int'(open_levels[$urandom_range(open_depth)]);
        return $urandom_range(int'(open_levels[open_depth]) + 3);
    endfunction

    task automatic send_random_chunk();
        int         roll;
        logic [7:0] b;
        roll = $urandom_range(99);
        if (roll < 55) begin
            send_code_line(pick_indent(), 6, 1'b0);
        end else if (roll < 66) begin
            send_blanks($urandom_range(9), 1'b0);
            send_text(CHAR_NL, 1'b0);
        end else if (roll < 77) begin
            send_blanks($urandom_range(6), 1'b0);
            send_text(CHAR_HASH, 1'b0);
            repeat ($urandom_range(5)) begin
                b = 8'($urandom_range(255));
                if (b == CHAR_NL) b = CHAR_HASH;
                send_text(b, 1'($urandom_range(1)));
            end
            send_text(CHAR_NL, 1'($urandom_range(1)));
        end else if (roll < 93) begin
            // noise: stray bytes that can break the line structure
            repeat ($urandom_range(1, 3)) send_text(8'($urandom_range(255)),
                                                    1'($urandom_range(1)));
        end else begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1,
                      1'b0, KIND_INDENT, '0);
        end
    endtask

    // Close everything, nest one blank deeper per line until the stack is full,
    // overflow it twice, then close everything at once: the longest token burst.
    task automatic send_deep_nest();
        send_byte(8'h00, 1'b0, 1'b1, 1'b0, KIND_INDENT, '0);
        repeat (NEST_DEPTH + 1) send_code_line(int'(open_levels[open_depth]) + 1, 1, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1, 1'b0, KIND_INDENT, '0);
    endtask

    // Drop valid and hold off until the block owes nothing.
    task automatic drain_tokens();
        @(negedge i_clk);
        text_ch.valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: stall at the rate of the current phase.
    initial begin
        token_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            token_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every token taken against the oldest one owed.
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n === 1'b1 && token_ch.valid === 1'b1 && token_ch.ready === 1'b1) begin
            if (tokens_due.size() == 0) begin
                $error("unexpected token: kind %0d line %0d",
                       token_ch.token_kind, token_ch.line_number);
                failures++;
            end else begin
                want = tokens_due.pop_front();
                if (token_ch.token_kind !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind,
                           token_ch.token_kind);
                    failures++;
                end
                if (token_ch.line_number !== want.line) begin
                    $error("line_number: expected %0d, got %0d", want.line,
                           token_ch.line_number);
                    failures++;
                end
                if (token_ch.last_of_run !== want.last) begin
                    $error("last_of_run: expected %0d, got %0d", want.last,
                           token_ch.last_of_run);
                    failures++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = 8'h00;
        text_ch.in_literal  = 1'b0;
        text_ch.end_of_text = 1'b0;
        gap_pct     = 0;
        stall_pct   = 0;
        phase_items = 0;
        failures    = 0;
        cycle_count = 0;
        clear_tracker();

        // Hold reset, then release it on a falling edge.
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table at full rate.
        foreach (dir_rows[i])
            send_byte(dir_rows[i].text_byte, dir_rows[i].lit, dir_rows[i].eot,
                      dir_rows[i].pinned, dir_rows[i].kind, dir_rows[i].line);
        drain_tokens();

        // Random text in four idling phases: none, sender gaps, receiver stalls, both
        // lightly. Each phase ends by pausing the sender until every token is back.
        // The deep nest alone fills the receiver-stall phase.
        for (int phase = 0; phase < 4; phase++) begin
            gap_pct     = (phase == 1) ? 48 : (phase == 3) ? 8 : 0;
            stall_pct   = (phase == 2) ? 48 : (phase == 3) ? 8 : 0;
            phase_items = 0;
            if (phase == 2) send_deep_nest();
            while (phase_items < PHASE_ITEMS) send_random_chunk();
            drain_tokens();
        end

        // Let any late or extra token show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0 && tokens_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
